// ===== design/vsm_pkg.sv =====
// ----------------------------------------------------------------------------
// vsm_pkg
// Shared constants, types and twiddle tables of the vibration spectrum monitor.
// ----------------------------------------------------------------------------
package vsm_pkg;

  localparam int WINDOW     = 256;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int HALF_W     = IDX_W - 1;
  localparam int STAGE_W    = $clog2(IDX_W);
  localparam int TW_DEPTH   = WINDOW / 2;
  localparam int PEAK_SHIFT = IDX_W - 1;
  localparam int ADDR_W     = 5;

  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint Q30_HALF = Q30_ONE / 2;
  localparam longint Q30_PI   = 64'sd3373259426;

  typedef enum logic [2:0] {
    REG_TEMP_WARN    = 3'd0,
    REG_TEMP_RESTART = 3'd1,
    REG_VIB_WARN     = 3'd2,
    REG_VIB_RESTART  = 3'd3,
    REG_SPEC_WARN    = 3'd4
  } vsm_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_PUSH,
    ST_WAIT,
    ST_FINISH
  } vsm_top_state_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_BF_RD,
    CS_BF_MUL,
    CS_BF_SUM,
    CS_BF_ROUND,
    CS_BF_WR_HI,
    CS_BF_WR_LO,
    CS_PK_RD,
    CS_PK_MUL,
    CS_PK_SUM,
    CS_PK_ROOT,
    CS_PK_CMP,
    CS_ACK
  } vsm_core_state_e;

  typedef struct packed {
    logic        push;
    logic [15:0] sample;
  } vsm_core_cmd_t;

  typedef struct packed {
    logic        idle;
    logic        ack;
    logic        window;
    logic [15:0] peak;
  } vsm_core_status_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } vsm_root16_t;

  typedef logic [TW_DEPTH-1:0][31:0] vsm_tw_tab_t;

  // q30 product truncated toward zero
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) / Q30_ONE;
  endfunction

  // cos / sin of 2*pi*m/WINDOW by truncated taylor series, evaluated at elaboration
  function automatic vsm_tw_tab_t build_twiddle(input bit want_sin);
    vsm_tw_tab_t tab;
    longint q, x, x2, c, s, cv, sv;
    int m;
    tab = '0;
    for (m = 0; m < TW_DEPTH; m++) begin
      q = longint'(m);
      if (m >= WINDOW / 4) q = q - WINDOW / 4;
      x  = (2 * q * Q30_PI) / WINDOW;
      x2 = qmul(x, x);
      c  = Q30_ONE;
      s  = Q30_ONE;
      c  = Q30_ONE - qmul(x2, c) / 132;
      s  = Q30_ONE - qmul(x2, s) / 156;
      c  = Q30_ONE - qmul(x2, c) / 90;
      s  = Q30_ONE - qmul(x2, s) / 110;
      c  = Q30_ONE - qmul(x2, c) / 56;
      s  = Q30_ONE - qmul(x2, s) / 72;
      c  = Q30_ONE - qmul(x2, c) / 30;
      s  = Q30_ONE - qmul(x2, s) / 42;
      c  = Q30_ONE - qmul(x2, c) / 12;
      s  = Q30_ONE - qmul(x2, s) / 20;
      c  = Q30_ONE - qmul(x2, c) / 2;
      s  = Q30_ONE - qmul(x2, s) / 6;
      s  = qmul(x, s);
      if (m >= WINDOW / 4) begin
        cv = -s;
        sv = c;
      end else begin
        cv = c;
        sv = s;
      end
      tab[m] = want_sin ? 32'(sv) : 32'(cv);
    end
    return tab;
  endfunction

  localparam vsm_tw_tab_t TW_COS = build_twiddle(1'b0);
  localparam vsm_tw_tab_t TW_SIN = build_twiddle(1'b1);

endpackage

// ===== design/vsm_intf.sv =====
// ----------------------------------------------------------------------------
// vsm_in_if / vsm_out_if
// Valid/ready channels carrying sensor words in and monitor words out.
// ----------------------------------------------------------------------------
interface vsm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_a;
  logic signed [15:0] accel_a_x;
  logic signed [15:0] accel_a_y;
  logic signed [15:0] accel_a_z;
  logic signed [15:0] temp_b;
  logic signed [15:0] accel_b_x;
  logic signed [15:0] accel_b_y;
  logic signed [15:0] accel_b_z;

  modport source (
    output valid, temp_a, accel_a_x, accel_a_y, accel_a_z,
    output temp_b, accel_b_x, accel_b_y, accel_b_z,
    input  ready
  );
  modport sink (
    input  valid, temp_a, accel_a_x, accel_a_y, accel_a_z,
    input  temp_b, accel_b_x, accel_b_y, accel_b_z,
    output ready
  );
endinterface

interface vsm_out_if;
  logic        valid;
  logic        ready;
  logic        restart_temp;
  logic        restart_vib;
  logic        warn_temp;
  logic        warn_vib;
  logic [15:0] magnitude_a;
  logic [15:0] magnitude_b;
  logic        window_done;
  logic [15:0] spectral_peak;
  logic        spectral_warn;

  modport source (
    output valid, restart_temp, restart_vib, warn_temp, warn_vib,
    output magnitude_a, magnitude_b, window_done, spectral_peak, spectral_warn,
    input  ready
  );
  modport sink (
    input  valid, restart_temp, restart_vib, warn_temp, warn_vib,
    input  magnitude_a, magnitude_b, window_done, spectral_peak, spectral_warn,
    output ready
  );
endinterface

// ===== design/vsm_fft_core.sv =====
// ----------------------------------------------------------------------------
// vsm_fft_core
// Window store, in-place radix-2 FFT over one work memory and peak search.
// ----------------------------------------------------------------------------
module vsm_fft_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vsm_pkg::vsm_core_cmd_t    cmd_i,
  output vsm_pkg::vsm_core_status_t status_o
);

  localparam logic [vsm_pkg::STAGE_W-1:0] LAST_STAGE = vsm_pkg::STAGE_W'(vsm_pkg::IDX_W - 1);
  localparam logic [vsm_pkg::STAGE_W-1:0] TW_SHIFT   = vsm_pkg::STAGE_W'(vsm_pkg::HALF_W);

  vsm_pkg::vsm_core_state_e state_q, state_d;

  logic [vsm_pkg::IDX_W-1:0]   fill_q;
  logic [vsm_pkg::STAGE_W-1:0] stage_q;
  logic [vsm_pkg::HALF_W-1:0]  bfly_q;
  logic [vsm_pkg::HALF_W-1:0]  bin_q;
  logic [4:0]                  step_q;
  logic                        window_q;
  logic [15:0]                 peak_q;
  logic [15:0]                 best_q;

  // work memory: {re, im}, sample k is stored at the bit-reversed index
  logic [63:0] work_mem [vsm_pkg::WINDOW];
  logic [63:0] rd_lo_q, rd_hi_q;

  logic signed [31:0] tw_c_q, tw_s_q;
  logic signed [31:0] u_re_q, u_im_q;
  logic signed [63:0] prod_q [4];
  logic signed [63:0] sum_tr_q, sum_ti_q;
  logic signed [33:0] tr_q, ti_q;
  logic [vsm_pkg::IDX_W-1:0] addr_lo_q, addr_hi_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;

  logic [vsm_pkg::HALF_W-1:0] lowmask, bf_i, tw_idx;
  logic [vsm_pkg::IDX_W-1:0]  bf_lo, bf_hi;
  logic [vsm_pkg::IDX_W-1:0]  rd_addr_lo, rd_addr_hi;
  logic                       mem_we;
  logic [vsm_pkg::IDX_W-1:0]  mem_wa;
  logic [63:0]                mem_wd;
  logic signed [31:0]         hi_re, hi_im, lo_re, lo_im;
  logic signed [63:0]         rnd_tr, rnd_ti;
  logic [35:0]                cand, trial;
  logic [31:0]                mag_full;
  logic [15:0]                mag16, best_next;

  function automatic logic [vsm_pkg::IDX_W-1:0] bit_rev(input logic [vsm_pkg::IDX_W-1:0] v);
    logic [vsm_pkg::IDX_W-1:0] r;
    for (int b = 0; b < vsm_pkg::IDX_W; b++) begin
      r[b] = v[vsm_pkg::IDX_W-1-b];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // butterfly addressing: insert a zero at bit stage into the butterfly count
  assign lowmask = ~({vsm_pkg::HALF_W{1'b1}} << stage_q);
  assign bf_i    = bfly_q & lowmask;
  assign bf_lo   = {bfly_q & ~lowmask, 1'b0} | {1'b0, bf_i};
  assign bf_hi   = bf_lo | (vsm_pkg::IDX_W'(1) << stage_q);
  assign tw_idx  = bf_i << (TW_SHIFT - stage_q);

  assign hi_re = rd_hi_q[63:32];
  assign hi_im = rd_hi_q[31:0];
  assign lo_re = rd_lo_q[63:32];
  assign lo_im = rd_lo_q[31:0];

  // q30 rounding, half away from zero
  assign rnd_tr = sum_tr_q[63] ? (vsm_pkg::Q30_HALF - 64'sd1) : vsm_pkg::Q30_HALF;
  assign rnd_ti = sum_ti_q[63] ? (vsm_pkg::Q30_HALF - 64'sd1) : vsm_pkg::Q30_HALF;

  assign cand  = {rem_q, rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  assign mag_full  = root_q >> vsm_pkg::PEAK_SHIFT;
  assign mag16     = (|mag_full[31:16]) ? 16'hffff : mag_full[15:0];
  assign best_next = (mag16 > best_q) ? mag16 : best_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vsm_pkg::CS_IDLE: begin
        if (cmd_i.push) begin
          state_d = (fill_q == '1) ? vsm_pkg::CS_BF_RD : vsm_pkg::CS_ACK;
        end
      end
      vsm_pkg::CS_BF_RD:    state_d = vsm_pkg::CS_BF_MUL;
      vsm_pkg::CS_BF_MUL:   state_d = vsm_pkg::CS_BF_SUM;
      vsm_pkg::CS_BF_SUM:   state_d = vsm_pkg::CS_BF_ROUND;
      vsm_pkg::CS_BF_ROUND: state_d = vsm_pkg::CS_BF_WR_HI;
      vsm_pkg::CS_BF_WR_HI: state_d = vsm_pkg::CS_BF_WR_LO;
      vsm_pkg::CS_BF_WR_LO: begin
        if (bfly_q == '1 && stage_q == LAST_STAGE) begin
          state_d = vsm_pkg::CS_PK_RD;
        end else begin
          state_d = vsm_pkg::CS_BF_RD;
        end
      end
      vsm_pkg::CS_PK_RD:  state_d = vsm_pkg::CS_PK_MUL;
      vsm_pkg::CS_PK_MUL: state_d = vsm_pkg::CS_PK_SUM;
      vsm_pkg::CS_PK_SUM: state_d = vsm_pkg::CS_PK_ROOT;
      vsm_pkg::CS_PK_ROOT: begin
        if (step_q == '1) state_d = vsm_pkg::CS_PK_CMP;
      end
      vsm_pkg::CS_PK_CMP: begin
        state_d = (bin_q == '1) ? vsm_pkg::CS_ACK : vsm_pkg::CS_PK_RD;
      end
      vsm_pkg::CS_ACK: state_d = vsm_pkg::CS_IDLE;
      default:         state_d = vsm_pkg::CS_IDLE;
    endcase
  end

  // memory ports and status
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = addr_hi_q;
    mem_wd     = {sat32(35'(u_re_q) - 35'(tr_q)), sat32(35'(u_im_q) - 35'(ti_q))};
    rd_addr_lo = (state_q == vsm_pkg::CS_PK_RD) ? {1'b0, bin_q} : bf_lo;
    rd_addr_hi = bf_hi;
    case (state_q)
      vsm_pkg::CS_IDLE: begin
        mem_we = cmd_i.push;
        mem_wa = bit_rev(fill_q);
        mem_wd = {16'h0000, cmd_i.sample, 32'h0000_0000};
      end
      vsm_pkg::CS_BF_WR_HI: begin
        mem_we = 1'b1;
      end
      vsm_pkg::CS_BF_WR_LO: begin
        mem_we = 1'b1;
        mem_wa = addr_lo_q;
        mem_wd = {sat32(35'(u_re_q) + 35'(tr_q)), sat32(35'(u_im_q) + 35'(ti_q))};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    status_o.idle   = (state_q == vsm_pkg::CS_IDLE);
    status_o.ack    = (state_q == vsm_pkg::CS_ACK);
    status_o.window = window_q;
    status_o.peak   = peak_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) work_mem[mem_wa] <= mem_wd;
    rd_lo_q <= work_mem[rd_addr_lo];
    rd_hi_q <= work_mem[rd_addr_hi];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vsm_pkg::CS_IDLE;
      fill_q   <= '0;
      stage_q  <= '0;
      bfly_q   <= '0;
      bin_q    <= '0;
      step_q   <= '0;
      window_q <= 1'b0;
      peak_q   <= '0;
      best_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        vsm_pkg::CS_IDLE: begin
          if (cmd_i.push) begin
            fill_q   <= fill_q + 1'b1;
            window_q <= (fill_q == '1);
            stage_q  <= '0;
            bfly_q   <= '0;
          end
        end
        vsm_pkg::CS_BF_WR_LO: begin
          if (bfly_q == '1) begin
            bfly_q <= '0;
            if (stage_q == LAST_STAGE) begin
              bin_q  <= vsm_pkg::HALF_W'(1);
              best_q <= '0;
            end else begin
              stage_q <= stage_q + 1'b1;
            end
          end else begin
            bfly_q <= bfly_q + 1'b1;
          end
        end
        vsm_pkg::CS_PK_SUM:  step_q <= '0;
        vsm_pkg::CS_PK_ROOT: step_q <= step_q + 1'b1;
        vsm_pkg::CS_PK_CMP: begin
          best_q <= best_next;
          if (bin_q == '1) begin
            peak_q <= best_next;
          end else begin
            bin_q <= bin_q + 1'b1;
          end
        end
        default: begin
          step_q <= step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      vsm_pkg::CS_BF_RD: begin
        tw_c_q    <= vsm_pkg::TW_COS[tw_idx];
        tw_s_q    <= vsm_pkg::TW_SIN[tw_idx];
        addr_lo_q <= bf_lo;
        addr_hi_q <= bf_hi;
      end
      vsm_pkg::CS_BF_MUL: begin
        u_re_q    <= lo_re;
        u_im_q    <= lo_im;
        prod_q[0] <= hi_re * tw_c_q;
        prod_q[1] <= hi_im * tw_s_q;
        prod_q[2] <= hi_im * tw_c_q;
        prod_q[3] <= hi_re * tw_s_q;
      end
      vsm_pkg::CS_BF_SUM: begin
        sum_tr_q <= prod_q[0] + prod_q[1];
        sum_ti_q <= prod_q[2] - prod_q[3];
      end
      vsm_pkg::CS_BF_ROUND: begin
        tr_q <= 34'((sum_tr_q + rnd_tr) >>> 30);
        ti_q <= 34'((sum_ti_q + rnd_ti) >>> 30);
      end
      vsm_pkg::CS_PK_MUL: begin
        prod_q[0] <= lo_re * lo_re;
        prod_q[1] <= lo_im * lo_im;
      end
      vsm_pkg::CS_PK_SUM: begin
        rad_q  <= 64'(prod_q[0]) + 64'(prod_q[1]);
        rem_q  <= '0;
        root_q <= '0;
      end
      vsm_pkg::CS_PK_ROOT: begin
        rad_q <= rad_q << 2;
        if (cand >= trial) begin
          rem_q  <= 34'(cand - trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= cand[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      default: begin
        rad_q <= rad_q;
      end
    endcase
  end

endmodule

// ===== design/vibration_spectrum_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// vibration_spectrum_monitor_unit
// Temperature and vibration limit checks with a windowed spectral peak.
// ----------------------------------------------------------------------------
// in_i carries one sensor word (two temperatures, two 3-axis accelerations);
// out_o returns one monitor word per input word, in order. The user must set
// the limits through the apb port only while the block is idle; the block
// itself does not enforce this. Reads return the limits.
// An ordinary word passes from accept to out_o.valid through squares, sum,
// a 16-step bit-serial square root for both magnitudes, a write of the first
// magnitude into the work memory, the core acknowledge and the output load.
// in_i.ready returns in the cycle after the load, so a new word is taken
// only after the previous result is loaded.
// Every 256th word completes a window and also runs the in-place FFT, one
// butterfly at a time on the single write port of the work memory, over
// (N/2)*log2(N) butterflies, then the peak search over bins 1..N/2-1 with
// one 32-step square root per bin, before that word's result is loaded.
// The output register frees the input side: the next word is accepted as
// soon as the previous result is loaded, even while out_o stalls; a finished
// result waits for the output register before the next word is taken.
// Reset clears the limits to their defaults, the fill count and held peak;
// memory contents are only read after being written.
module vibration_spectrum_monitor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  vsm_in_if.sink                     in_i,
  vsm_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  vsm_pkg::vsm_top_state_e state_q, state_d;

  logic signed [15:0] temp_warn_q, temp_restart_q;
  logic [15:0]        vib_warn_q, vib_restart_q, spec_warn_q;
  logic               cfg_wr;
  vsm_pkg::vsm_reg_e  cfg_sel;

  logic signed [15:0] temp_a_q, temp_b_q;
  logic signed [15:0] acc_q [6];
  logic [31:0]        sq_q [6];
  logic [31:0]        rad_a_q, rad_b_q;
  vsm_pkg::vsm_root16_t root_a_q, root_b_q, root_a_nx, root_b_nx;
  logic [3:0]         step_q;
  logic               window_q;

  logic               out_valid_q;
  logic               load_out;
  logic               rt, rv, wt, wv, sw;
  logic               o_rt_q, o_rv_q, o_wt_q, o_wv_q, o_done_q, o_sw_q;
  logic [15:0]        o_mag_a_q, o_mag_b_q, o_peak_q;

  vsm_pkg::vsm_core_cmd_t    core_cmd;
  vsm_pkg::vsm_core_status_t core_st;

  function automatic vsm_pkg::vsm_root16_t root_step(input vsm_pkg::vsm_root16_t cur,
                                                     input logic [1:0] pair);
    logic [19:0] cand, trial;
    vsm_pkg::vsm_root16_t nxt;
    cand  = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (cand >= trial) begin
      nxt.rem  = 18'(cand - trial);
      nxt.root = {cur.root[14:0], 1'b1};
    end else begin
      nxt.rem  = cand[17:0];
      nxt.root = {cur.root[14:0], 1'b0};
    end
    return nxt;
  endfunction

  vsm_fft_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (core_cmd),
    .status_o (core_st)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = vsm_pkg::vsm_reg_e'(paddr[vsm_pkg::ADDR_W-1:2]);

  always_comb begin
    case (cfg_sel)
      vsm_pkg::REG_TEMP_WARN:    prdata = {{16{temp_warn_q[15]}}, temp_warn_q};
      vsm_pkg::REG_TEMP_RESTART: prdata = {{16{temp_restart_q[15]}}, temp_restart_q};
      vsm_pkg::REG_VIB_WARN:     prdata = {16'h0000, vib_warn_q};
      vsm_pkg::REG_VIB_RESTART:  prdata = {16'h0000, vib_restart_q};
      vsm_pkg::REG_SPEC_WARN:    prdata = {16'h0000, spec_warn_q};
      default:                   prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_warn_q    <= 16'sd1760;
      temp_restart_q <= 16'sd3040;
      vib_warn_q     <= 16'd2867;
      vib_restart_q  <= 16'd9216;
      spec_warn_q    <= 16'd1434;
    end else if (cfg_wr) begin
      case (cfg_sel)
        vsm_pkg::REG_TEMP_WARN:    temp_warn_q    <= pwdata[15:0];
        vsm_pkg::REG_TEMP_RESTART: temp_restart_q <= pwdata[15:0];
        vsm_pkg::REG_VIB_WARN:     vib_warn_q     <= pwdata[15:0];
        vsm_pkg::REG_VIB_RESTART:  vib_restart_q  <= pwdata[15:0];
        vsm_pkg::REG_SPEC_WARN:    spec_warn_q    <= pwdata[15:0];
        default:                   spec_warn_q    <= spec_warn_q;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vsm_pkg::ST_IDLE:   if (in_i.valid) state_d = vsm_pkg::ST_SQUARE;
      vsm_pkg::ST_SQUARE: state_d = vsm_pkg::ST_SUM;
      vsm_pkg::ST_SUM:    state_d = vsm_pkg::ST_ROOT;
      vsm_pkg::ST_ROOT:   if (step_q == '1) state_d = vsm_pkg::ST_PUSH;
      vsm_pkg::ST_PUSH:   state_d = vsm_pkg::ST_WAIT;
      vsm_pkg::ST_WAIT:   if (core_st.ack) state_d = vsm_pkg::ST_FINISH;
      vsm_pkg::ST_FINISH: if (!out_valid_q || out_o.ready) state_d = vsm_pkg::ST_IDLE;
      default:            state_d = vsm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready      = (state_q == vsm_pkg::ST_IDLE);
    core_cmd.push   = (state_q == vsm_pkg::ST_PUSH);
    core_cmd.sample = root_a_q.root;
    load_out        = (state_q == vsm_pkg::ST_FINISH) && (!out_valid_q || out_o.ready);
  end

  assign root_a_nx = root_step(root_a_q, rad_a_q[31:30]);
  assign root_b_nx = root_step(root_b_q, rad_b_q[31:30]);

  // limit flags of the finished word
  assign rt = (temp_a_q > temp_restart_q) || (temp_b_q > temp_restart_q);
  assign rv = (root_a_q.root > vib_restart_q) || (root_b_q.root > vib_restart_q);
  assign wt = (temp_a_q >= temp_warn_q && temp_a_q <= temp_restart_q) ||
              (temp_b_q >= temp_warn_q && temp_b_q <= temp_restart_q);
  assign wv = (root_a_q.root >= vib_warn_q && root_a_q.root <= vib_restart_q) ||
              (root_b_q.root >= vib_warn_q && root_b_q.root <= vib_restart_q);
  assign sw = window_q && (core_st.peak > spec_warn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsm_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vsm_pkg::ST_SUM) begin
        step_q <= '0;
      end else if (state_q == vsm_pkg::ST_ROOT) begin
        step_q <= step_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      vsm_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          temp_a_q <= in_i.temp_a;
          temp_b_q <= in_i.temp_b;
          acc_q[0] <= in_i.accel_a_x;
          acc_q[1] <= in_i.accel_a_y;
          acc_q[2] <= in_i.accel_a_z;
          acc_q[3] <= in_i.accel_b_x;
          acc_q[4] <= in_i.accel_b_y;
          acc_q[5] <= in_i.accel_b_z;
        end
      end
      vsm_pkg::ST_SQUARE: begin
        for (int k = 0; k < 6; k++) begin
          sq_q[k] <= 32'(acc_q[k]) * 32'(acc_q[k]);
        end
      end
      vsm_pkg::ST_SUM: begin
        rad_a_q  <= sq_q[0] + sq_q[1] + sq_q[2];
        rad_b_q  <= sq_q[3] + sq_q[4] + sq_q[5];
        root_a_q <= '0;
        root_b_q <= '0;
      end
      vsm_pkg::ST_ROOT: begin
        rad_a_q  <= rad_a_q << 2;
        rad_b_q  <= rad_b_q << 2;
        root_a_q <= root_a_nx;
        root_b_q <= root_b_nx;
      end
      vsm_pkg::ST_WAIT: begin
        if (core_st.ack) window_q <= core_st.window;
      end
      default: begin
        window_q <= window_q;
      end
    endcase
    if (load_out) begin
      o_rt_q    <= rt;
      o_rv_q    <= rv;
      o_wt_q    <= wt;
      o_wv_q    <= wv;
      o_mag_a_q <= root_a_q.root;
      o_mag_b_q <= root_b_q.root;
      o_done_q  <= window_q;
      o_peak_q  <= core_st.peak;
      o_sw_q    <= sw;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.restart_temp  = o_rt_q;
  assign out_o.restart_vib   = o_rv_q;
  assign out_o.warn_temp     = o_wt_q;
  assign out_o.warn_vib      = o_wv_q;
  assign out_o.magnitude_a   = o_mag_a_q;
  assign out_o.magnitude_b   = o_mag_b_q;
  assign out_o.window_done   = o_done_q;
  assign out_o.spectral_peak = o_peak_q;
  assign out_o.spectral_warn = o_sw_q;

`ifndef ASSERT_OFF
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_cmd.push |-> core_st.idle)
    else $error("sample pushed while fft core busy");

  a_ack_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.ack |-> (state_q == vsm_pkg::ST_WAIT))
    else $error("core ack outside wait state");

  a_warn_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.spectral_warn) |-> out_o.window_done)
    else $error("spectral warn without window");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("result lost at output register");
`endif

endmodule
